// ===== sv/mvsm_pkg.sv =====
// Package: shared types, constants and enums for the multi-voice sample mixer.
package mvsm_pkg;

    localparam int VOICES_DEF       = 24;
    localparam int SAMPLE_WORDS_DEF = 65536;

    localparam logic [2:0] REQ_WRITE  = 3'd0;
    localparam logic [2:0] REQ_START  = 3'd1;
    localparam logic [2:0] REQ_UPDATE = 3'd2;
    localparam logic [2:0] REQ_STOP   = 3'd3;
    localparam logic [2:0] REQ_MIX    = 3'd4;

    localparam logic [31:0] LOOP_FOREVER = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FIND,
        ST_VLOAD,
        ST_RD0,
        ST_RD1,
        ST_INTERP,
        ST_SCALE,
        ST_ACCUM,
        ST_NEXT,
        ST_DONE,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic        clr_acc;
        logic        ld_voice;
        logic        rd0;
        logic        rd1;
        logic        interp;
        logic        scale;
        logic        accum;
        logic        do_write;
        logic        do_start;
        logic        do_update;
        logic        do_stop;
        logic        finish;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic live;
    } dp_stat_t;

endpackage

// ===== sv/mvsm_ctrl.sv =====
// Controller: sequences one request and the per-voice walks of a start and a mix.
module mvsm_ctrl import mvsm_pkg::*; #(
    parameter int VOICES = VOICES_DEF,
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  req_type,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [VW-1:0] vidx,
    output dp_cmd_t     cmd,
    input  dp_stat_t    stat
);

    ctrl_state_t state_reg, state_next;
    logic [VW-1:0] vidx_reg, vidx_next;
    logic [2:0]    req_reg, req_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            vidx_reg  <= '0;
            req_reg   <= REQ_WRITE;
        end else begin
            state_reg <= state_next;
            vidx_reg  <= vidx_next;
            req_reg   <= req_next;
        end
    end

    assign vidx = vidx_reg;

    always_comb begin
        state_next = state_reg;
        vidx_next  = vidx_reg;
        req_next   = req_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next   = req_type;
                    vidx_next  = '0;
                    cmd.clr_acc = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (req_reg)
                    REQ_WRITE:  begin cmd.do_write  = 1'b1; state_next = ST_DONE; end
                    REQ_START:  state_next = ST_FIND;
                    REQ_UPDATE: begin cmd.do_update = 1'b1; state_next = ST_DONE; end
                    REQ_STOP:   begin cmd.do_stop   = 1'b1; state_next = ST_DONE; end
                    REQ_MIX:    state_next = ST_VLOAD;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_FIND: begin
                if (!stat.busy) begin
                    cmd.do_start = 1'b1;
                    state_next   = ST_DONE;
                end else if (vidx_reg == VW'(VOICES - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    vidx_next = vidx_reg + 1'b1;
                end
            end
            ST_VLOAD: begin
                cmd.ld_voice = 1'b1;
                state_next   = ST_RD0;
            end
            ST_RD0: begin
                if (stat.live) begin
                    cmd.rd0    = 1'b1;
                    state_next = ST_RD1;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_RD1:    begin cmd.rd1 = 1'b1;    state_next = ST_INTERP; end
            ST_INTERP: begin cmd.interp = 1'b1; state_next = ST_SCALE; end
            ST_SCALE:  begin cmd.scale = 1'b1;  state_next = ST_ACCUM; end
            ST_ACCUM:  begin cmd.accum = 1'b1;  state_next = ST_NEXT; end
            ST_NEXT: begin
                if (vidx_reg == VW'(VOICES - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    vidx_next  = vidx_reg + 1'b1;
                    state_next = ST_VLOAD;
                end
            end
            ST_DONE: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready and valid together");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_start |-> req_reg == REQ_START) else $error("stray start");

endmodule

// ===== sv/mvsm_datapath.sv =====
// Datapath: sample memory, voice state, interpolation, scaling and mix sums.
module mvsm_datapath import mvsm_pkg::*; #(
    parameter int VOICES       = VOICES_DEF,
    parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF,
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1,
    localparam int AW = $clog2(SAMPLE_WORDS)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [4:0]         s_voice,
    input  logic [15:0]        s_address,
    input  logic signed [15:0] s_sample,
    input  logic [15:0]        s_length,
    input  logic [23:0]        s_step,
    input  logic [14:0]        s_left_gain,
    input  logic [14:0]        s_right_gain,
    input  logic [15:0]        s_rep_start,
    input  logic [15:0]        s_rep_end,
    input  logic [31:0]        s_rep_count,
    input  logic [VW-1:0]      vidx,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    output logic signed [15:0] m_left_out,
    output logic signed [15:0] m_right_out,
    output logic [4:0]         m_voice_given,
    output logic               m_accepted,
    output logic [4:0]         m_active_voices
);

    logic [15:0] mem [SAMPLE_WORDS];

    logic [VOICES-1:0] busy_reg;
    logic [15:0] base_a  [VOICES];
    logic [15:0] len_a   [VOICES];
    logic [32:0] phase_a [VOICES];
    logic [23:0] step_a  [VOICES];
    logic [14:0] lg_a    [VOICES];
    logic [14:0] rg_a    [VOICES];
    logic [15:0] ls_a    [VOICES];
    logic [15:0] le_a    [VOICES];
    logic [31:0] lc_a    [VOICES];

    logic [4:0]  voice_reg;
    logic [15:0] addr_reg, len_in_reg, ls_in_reg, le_in_reg;
    logic [15:0] samp_reg;
    logic [23:0] step_in_reg;
    logic [14:0] lg_in_reg, rg_in_reg;
    logic [31:0] lc_in_reg;

    logic [15:0] cbase_reg, clen_reg, cls_reg, cle_reg;
    logic [32:0] cphase_reg;
    logic [23:0] cstep_reg;
    logic [14:0] clg_reg, crg_reg;
    logic [31:0] clc_reg;
    logic        clive_reg;

    logic signed [15:0] s0_reg, s1_reg;
    logic signed [16:0] s_reg;
    logic signed [31:0] lp_reg, rp_reg;
    logic signed [21:0] lsum_reg, rsum_reg;
    logic [15:0] rdata_reg;
    logic        sum_en_reg;

    logic [15:0] lout_reg, rout_reg;
    logic [4:0]  given_reg, given_next, act_reg;
    logic        ok_reg, ok_next;

    logic [23:0] step_fix;
    logic [16:0] frame_now;
    logic [33:0] phase_adv;
    logic [32:0] phase_new;
    logic        take_loop;
    logic [AW-1:0] addr0, addr1;
    logic        has_next;
    logic signed [16:0] diff;
    logic signed [33:0] dprod;
    logic signed [32:0] lprod, rprod;
    logic [5:0]  cnt;
    logic        vsel_ok;

    assign step_fix  = (step_in_reg == '0) ? 24'd1 : step_in_reg;
    assign frame_now = cphase_reg[32:16];
    assign has_next  = (frame_now + 17'd1) < {1'b0, clen_reg};
    assign addr0     = AW'({1'b0, cbase_reg} + frame_now);
    assign addr1     = AW'({1'b0, cbase_reg} + frame_now + 17'd1);
    assign phase_adv = {1'b0, cphase_reg} + {10'd0, cstep_reg};
    assign take_loop = (clc_reg != '0) && (cle_reg > cls_reg)
                    && (phase_adv[33:16] >= {2'b0, cle_reg});
    assign phase_new = take_loop ? {1'b0, cls_reg, 16'd0} : phase_adv[32:0];
    assign diff      = 17'(s1_reg) - 17'(s0_reg);
    assign dprod     = 34'(diff) * $signed({1'b0, cphase_reg[15:0]});
    assign lprod     = 33'(s_reg) * $signed({1'b0, clg_reg});
    assign rprod     = 33'(s_reg) * $signed({1'b0, crg_reg});
    assign vsel_ok   = ({2'b0, voice_reg} < 7'(VOICES));

    always_comb begin
        cnt = '0;
        for (int i = 0; i < VOICES; i++) cnt = cnt + 6'(busy_reg[i]);
    end

    always_comb begin
        stat.busy = busy_reg[vidx];
        stat.live = clive_reg;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            voice_reg   <= s_voice;
            addr_reg    <= s_address;
            samp_reg    <= s_sample;
            len_in_reg  <= s_length;
            step_in_reg <= s_step;
            lg_in_reg   <= s_left_gain;
            rg_in_reg   <= s_right_gain;
            ls_in_reg   <= s_rep_start;
            le_in_reg   <= s_rep_end;
            lc_in_reg   <= s_rep_count;
        end
        if (cmd.do_write) mem[AW'(addr_reg)] <= samp_reg;
        if (cmd.rd0) rdata_reg <= mem[addr0];
        if (cmd.rd1) rdata_reg <= mem[addr1];
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_voice) begin
            cbase_reg  <= base_a[vidx];
            clen_reg   <= len_a[vidx];
            cphase_reg <= phase_a[vidx];
            cstep_reg  <= step_a[vidx];
            clg_reg    <= lg_a[vidx];
            crg_reg    <= rg_a[vidx];
            cls_reg    <= ls_a[vidx];
            cle_reg    <= le_a[vidx];
            clc_reg    <= lc_a[vidx];
        end
        if (cmd.rd1) s0_reg <= rdata_reg;
        if (cmd.interp) begin
            s1_reg <= has_next ? rdata_reg : s0_reg;
        end
        if (cmd.scale) s_reg <= 17'(s0_reg) + 17'(dprod >>> 16);
        if (cmd.accum) begin
            lp_reg <= 32'(lprod >>> 15);
            rp_reg <= 32'(rprod >>> 15);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= '0;
            clive_reg <= 1'b0;
            lsum_reg  <= '0;
            rsum_reg  <= '0;
            lout_reg  <= '0;
            rout_reg  <= '0;
            given_reg <= '0;
            ok_reg    <= 1'b0;
            act_reg   <= '0;
            for (int i = 0; i < VOICES; i++) begin
                base_a[i] <= '0; len_a[i] <= '0; phase_a[i] <= '0; step_a[i] <= '0;
                lg_a[i] <= '0; rg_a[i] <= '0; ls_a[i] <= '0; le_a[i] <= '0;
                lc_a[i] <= '0;
            end
        end else begin
            if (cmd.clr_acc) begin
                lsum_reg  <= '0;
                rsum_reg  <= '0;
                given_reg <= '0;
                ok_reg    <= 1'b0;
            end
            if (cmd.ld_voice) begin
                ok_reg    <= 1'b1;
                clive_reg <= busy_reg[vidx] && (phase_a[vidx][32:16] < {1'b0, len_a[vidx]});
                if (busy_reg[vidx] && (phase_a[vidx][32:16] >= {1'b0, len_a[vidx]}))
                    busy_reg[vidx] <= 1'b0;
            end
            if (cmd.rd1) begin
                phase_a[vidx] <= phase_new;
                if (take_loop && clc_reg != LOOP_FOREVER) lc_a[vidx] <= clc_reg - 1'b1;
                if (phase_new[32:16] >= {1'b0, clen_reg}) busy_reg[vidx] <= 1'b0;
            end
            if (cmd.do_write) ok_reg <= 1'b1;
            if (cmd.do_start) begin
                busy_reg[vidx] <= 1'b1;
                base_a[vidx]   <= addr_reg;
                len_a[vidx]    <= len_in_reg;
                phase_a[vidx]  <= '0;
                step_a[vidx]   <= step_fix;
                lg_a[vidx]     <= lg_in_reg;
                rg_a[vidx]     <= rg_in_reg;
                ls_a[vidx]     <= ls_in_reg;
                le_a[vidx]     <= le_in_reg;
                lc_a[vidx]     <= lc_in_reg;
                given_reg      <= 5'(vidx);
                ok_reg         <= 1'b1;
            end
            if (cmd.do_update && vsel_ok && busy_reg[VW'(voice_reg)]) begin
                step_a[VW'(voice_reg)] <= step_fix;
                lg_a[VW'(voice_reg)]   <= lg_in_reg;
                rg_a[VW'(voice_reg)]   <= rg_in_reg;
                ok_reg <= 1'b1;
            end
            if (cmd.do_stop && vsel_ok && busy_reg[VW'(voice_reg)]) begin
                busy_reg[VW'(voice_reg)] <= 1'b0;
                ok_reg <= 1'b1;
            end
            if (cmd.finish) begin
                act_reg <= 5'(cnt);
                lout_reg <= (lsum_reg > 22'sd32767) ? 16'h7FFF :
                            (lsum_reg < -22'sd32768) ? 16'h8000 : 16'(lsum_reg);
                rout_reg <= (rsum_reg > 22'sd32767) ? 16'h7FFF :
                            (rsum_reg < -22'sd32768) ? 16'h8000 : 16'(rsum_reg);
            end
            if (sum_en_reg) begin
                lsum_reg <= lsum_reg + 22'(lp_reg);
                rsum_reg <= rsum_reg + 22'(rp_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) sum_en_reg <= 1'b0;
        else          sum_en_reg <= cmd.accum;
    end

    assign given_next = given_reg;
    assign ok_next    = ok_reg;

    assign m_left_out      = lout_reg;
    assign m_right_out     = rout_reg;
    assign m_voice_given   = given_next;
    assign m_accepted      = ok_next;
    assign m_active_voices = act_reg;

endmodule

// ===== sv/multi_voice_sample_mixer.sv =====
// Top level: twenty-four-voice PCM playback mixer.
//
// One request enters on the s_ channel (valid/ready) and yields exactly one
// result on the m_ channel (valid/ready). Requests: write a sample word,
// start a voice on the first free one, update a voice's gains and step, stop
// a voice, or mix one stereo frame.
// A start walks the voices for a free one. A mix walks every voice through
// load, two sample-memory reads, interpolation, scaling and accumulation;
// an idle voice goes on to the next after its load. The voices take turns
// on the single-port sample memory and the shared multipliers. One request
// is in work at a time; the next is taken in the cycle after the result is
// handed off.
// Reset (aresetn low, synchronous) clears all voices to idle; sample memory
// content is undefined until written. While the receiver holds m_ready low
// the result stays on the ports and no new request is taken.
module multi_voice_sample_mixer import mvsm_pkg::*; #(
    parameter int VOICES       = VOICES_DEF,
    parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_req_type,
    input  logic [4:0]         s_voice,
    input  logic [15:0]        s_address,
    input  logic signed [15:0] s_sample,
    input  logic [15:0]        s_length,
    input  logic [23:0]        s_step,
    input  logic [14:0]        s_left_gain,
    input  logic [14:0]        s_right_gain,
    input  logic [15:0]        s_rep_start,
    input  logic [15:0]        s_rep_end,
    input  logic [31:0]        s_rep_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_left_out,
    output logic signed [15:0] m_right_out,
    output logic [4:0]         m_voice_given,
    output logic               m_accepted,
    output logic [4:0]         m_active_voices
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic [VW-1:0] vidx;
    dp_cmd_t       cmd;
    dp_stat_t      stat;

    mvsm_ctrl #(.VOICES(VOICES)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .req_type(s_req_type),
        .m_valid, .m_ready, .vidx, .cmd, .stat
    );

    mvsm_datapath #(.VOICES(VOICES), .SAMPLE_WORDS(SAMPLE_WORDS)) u_dp (
        .aclk, .aresetn, .s_valid, .s_ready, .s_voice, .s_address, .s_sample,
        .s_length, .s_step, .s_left_gain, .s_right_gain, .s_rep_start,
        .s_rep_end, .s_rep_count, .vidx, .cmd, .stat,
        .m_left_out, .m_right_out, .m_voice_given, .m_accepted, .m_active_voices
    );

endmodule

// ===== tb/tb_multi_voice_sample_mixer.sv =====
// Testbench for the multi-voice sample mixer: directed table then random requests vs predictor.
module tb_multi_voice_sample_mixer;
    import mvsm_pkg::*;

    localparam int NV = 24;
    localparam int RAND_ITEMS = 520;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [2:0] REQ_RESERVED = 3'd7;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  voice;
        logic [15:0] address;
        logic [15:0] sample;
        logic [15:0] length;
        logic [23:0] step;
        logic [14:0] left_gain;
        logic [14:0] right_gain;
        logic [15:0] rep_start;
        logic [15:0] rep_end;
        logic [31:0] rep_count;
    } request_t;

    typedef struct packed {
        logic [15:0] left_out;
        logic [15:0] right_out;
        logic [4:0]  voice_given;
        logic        accepted;
        logic [4:0]  active_voices;
    } mix_result_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [2:0] s_req_type = 0;
    logic [4:0] s_voice = 0;
    logic [15:0] s_address = 0;
    logic signed [15:0] s_sample = 0;
    logic [15:0] s_length = 0;
    logic [23:0] s_step = 0;
    logic [14:0] s_left_gain = 0;
    logic [14:0] s_right_gain = 0;
    logic [15:0] s_rep_start = 0;
    logic [15:0] s_rep_end = 0;
    logic [31:0] s_rep_count = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [15:0] m_left_out;
    logic signed [15:0] m_right_out;
    logic [4:0] m_voice_given;
    logic m_accepted;
    logic [4:0] m_active_voices;

    multi_voice_sample_mixer uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_voice(s_voice), .s_address(s_address),
        .s_sample(s_sample), .s_length(s_length), .s_step(s_step),
        .s_left_gain(s_left_gain), .s_right_gain(s_right_gain),
        .s_rep_start(s_rep_start), .s_rep_end(s_rep_end),
        .s_rep_count(s_rep_count),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_left_out(m_left_out), .m_right_out(m_right_out),
        .m_voice_given(m_voice_given), .m_accepted(m_accepted),
        .m_active_voices(m_active_voices)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // predictor state
    logic [15:0] pcm_mem [int];
    bit          v_busy [NV];
    logic [15:0] v_base [NV];
    logic [15:0] v_len [NV];
    logic [32:0] v_phase [NV];
    logic [23:0] v_step [NV];
    logic [14:0] v_lgain [NV];
    logic [14:0] v_rgain [NV];
    logic [15:0] v_lstart [NV];
    logic [15:0] v_lend [NV];
    logic [31:0] v_loops [NV];

    mix_result_t expected_results [$];
    bit          has_fixed [$];
    mix_result_t fixed_results [$];
    int          fail_count = 0;
    int          seen_count = 0;
    int          sent_count = 0;
    longint      cycle_count = 0;

    function automatic longint floor_shr(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint pcm_read(logic [15:0] a);
        if (pcm_mem.exists(a)) return longint'($signed(pcm_mem[a]));
        return 0;
    endfunction

    function automatic mix_result_t predict_mix(request_t r);
        mix_result_t res;
        longint lsum, rsum, s0, s1, s;
        logic [32:0] frame;
        res = '{default: 0};
        lsum = 0;
        rsum = 0;
        case (r.req_type)
            REQ_WRITE: begin
                pcm_mem[r.address] = r.sample;
                res.accepted = 1;
            end
            REQ_START: begin
                for (int v = 0; v < NV; v++) begin
                    if (!v_busy[v]) begin
                        v_busy[v] = 1;
                        v_base[v] = r.address;
                        v_len[v] = r.length;
                        v_phase[v] = 0;
                        v_step[v] = (r.step == 0) ? 24'd1 : r.step;
                        v_lgain[v] = r.left_gain;
                        v_rgain[v] = r.right_gain;
                        v_lstart[v] = r.rep_start;
                        v_lend[v] = r.rep_end;
                        v_loops[v] = r.rep_count;
                        res.voice_given = 5'(v);
                        res.accepted = 1;
                        break;
                    end
                end
            end
            REQ_UPDATE: begin
                if (r.voice < NV && v_busy[r.voice]) begin
                    v_step[r.voice] = (r.step == 0) ? 24'd1 : r.step;
                    v_lgain[r.voice] = r.left_gain;
                    v_rgain[r.voice] = r.right_gain;
                    res.accepted = 1;
                end
            end
            REQ_STOP: begin
                if (r.voice < NV && v_busy[r.voice]) begin
                    v_busy[r.voice] = 0;
                    res.accepted = 1;
                end
            end
            REQ_MIX: begin
                for (int v = 0; v < NV; v++) begin
                    if (!v_busy[v]) continue;
                    frame = v_phase[v] >> 16;
                    if (frame >= v_len[v]) begin
                        v_busy[v] = 0;
                        continue;
                    end
                    s0 = pcm_read(v_base[v] + frame[15:0]);
                    s1 = (frame + 1 < v_len[v]) ? pcm_read(v_base[v] + frame[15:0] + 16'd1)
                                                 : s0;
                    s = s0 + floor_shr((s1 - s0) * longint'(v_phase[v][15:0]), 16);
                    lsum += floor_shr(s * longint'(v_lgain[v]), 15);
                    rsum += floor_shr(s * longint'(v_rgain[v]), 15);
                    v_phase[v] = v_phase[v] + v_step[v];
                    frame = v_phase[v] >> 16;
                    if (v_loops[v] != 0 && v_lend[v] > v_lstart[v] && frame >= v_lend[v]) begin
                        v_phase[v] = {1'b0, v_lstart[v], 16'd0};
                        if (v_loops[v] != LOOP_FOREVER) v_loops[v]--;
                    end
                    if ((v_phase[v] >> 16) >= v_len[v]) v_busy[v] = 0;
                end
                if (lsum > 32767) lsum = 32767;
                if (lsum < -32768) lsum = -32768;
                if (rsum > 32767) rsum = 32767;
                if (rsum < -32768) rsum = -32768;
                res.left_out = lsum[15:0];
                res.right_out = rsum[15:0];
                res.accepted = 1;
            end
            default: ;
        endcase
        res.active_voices = 0;
        for (int v = 0; v < NV; v++) res.active_voices += 5'(v_busy[v]);
        return res;
    endfunction

    // sample addresses the random voices may touch; all are written first
    localparam int REGION = 256;

    function automatic request_t blank_req(logic [2:0] t);
        request_t r;
        r = '{default: 0};
        r.req_type = t;
        return r;
    endfunction

    function automatic request_t rand_req();
        request_t r;
        int k;
        r.req_type = REQ_MIX;
        r.voice = 5'($urandom_range(0, 31));
        r.address = 16'($urandom);
        r.sample = 16'($urandom);
        r.length = 16'($urandom);
        r.step = 24'($urandom);
        r.left_gain = 15'($urandom);
        r.right_gain = 15'($urandom);
        r.rep_start = 16'($urandom);
        r.rep_end = 16'($urandom);
        r.rep_count = $urandom;
        k = $urandom_range(0, 99);
        if (k < 15) begin
            r.req_type = REQ_WRITE;
            if ($urandom_range(0, 1) != 0) r.address = 16'($urandom_range(0, REGION + 1));
        end else if (k < 30) begin
            r.req_type = REQ_START;
            r.length = 16'($urandom_range(1, 40));
            r.address = 16'($urandom_range(0, REGION - 40));
            r.step = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 3))
                                                  : 24'($urandom_range(0, 'h30000));
            r.rep_start = 16'($urandom_range(0, 20));
            r.rep_end = 16'($urandom_range(0, 45));
            case ($urandom_range(0, 3))
                0: r.rep_count = 0;
                1: r.rep_count = LOOP_FOREVER;
                default: r.rep_count = $urandom_range(1, 4);
            endcase
        end else if (k < 40) begin
            r.req_type = REQ_UPDATE;
            r.step = 24'($urandom_range(0, 'h30000));
        end else if (k < 47) begin
            r.req_type = REQ_STOP;
        end else if (k < 50) begin
            r.req_type = 3'($urandom_range(REQ_MIX + 1, REQ_RESERVED));
        end
        if (r.req_type == REQ_START && $urandom_range(0, 19) == 0)
            r.address = 16'hFFF0;
        return r;
    endfunction

    request_t directed_rows [$];
    bit       directed_fixed [$];
    mix_result_t directed_exp [$];

    task automatic add_row(request_t r, bit fixed, mix_result_t e);
        directed_rows.push_back(r);
        directed_fixed.push_back(fixed);
        directed_exp.push_back(e);
    endtask

    task automatic send_req(request_t r, bit fixed, mix_result_t e);
        mix_result_t pred;
        s_req_type <= r.req_type;
        s_voice <= r.voice;
        s_address <= r.address;
        s_sample <= r.sample;
        s_length <= r.length;
        s_step <= r.step;
        s_left_gain <= r.left_gain;
        s_right_gain <= r.right_gain;
        s_rep_start <= r.rep_start;
        s_rep_end <= r.rep_end;
        s_rep_count <= r.rep_count;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        pred = predict_mix(r);
        expected_results.push_back(pred);
        has_fixed.push_back(fixed);
        fixed_results.push_back(e);
        sent_count++;
        @(negedge aclk);
    endtask

    task automatic build_table();
        request_t r;
        mix_result_t e;
        mix_result_t none;
        none = '{default: 0};
        e = '{default: 0};
        r = blank_req(REQ_MIX);
        e.accepted = 1;
        add_row(r, 1, e);
        e = '{default: 0};
        r = blank_req(REQ_STOP);
        r.voice = 31;
        add_row(r, 1, e);
        r = blank_req(REQ_UPDATE);
        r.voice = 5;
        add_row(r, 1, e);
        r = blank_req(REQ_RESERVED);
        add_row(r, 1, e);
        r = blank_req(REQ_WRITE);
        r.address = 16'hFFFF;
        r.sample = 16'h7FFF;
        e.accepted = 1;
        add_row(r, 1, e);
        r.address = 0;
        r.sample = 16'h8000;
        add_row(r, 1, e);
        r.address = 1;
        r.sample = 16'h7FFF;
        add_row(r, 0, none);
        // wrap across the top of memory, full gain, looping forever
        r = blank_req(REQ_START);
        r.address = 16'hFFFF;
        r.length = 2;
        r.step = 0;
        r.left_gain = 15'h7FFF;
        r.right_gain = 15'h7FFF;
        r.rep_start = 0;
        r.rep_end = 1;
        r.rep_count = LOOP_FOREVER;
        add_row(r, 0, none);
        r.address = 0;
        r.step = 24'hFFFFFF;
        r.left_gain = 0;
        r.rep_count = 1;
        add_row(r, 0, none);
        r = blank_req(REQ_MIX);
        add_row(r, 0, none);
        add_row(r, 0, none);
        r = blank_req(REQ_UPDATE);
        r.voice = 0;
        r.step = 24'h8000;
        r.left_gain = 15'h7FFF;
        add_row(r, 0, none);
        r = blank_req(REQ_MIX);
        add_row(r, 0, none);
        r = blank_req(REQ_START);
        r.length = 0;
        add_row(r, 0, none);
        r = blank_req(REQ_MIX);
        add_row(r, 0, none);
        r = blank_req(REQ_STOP);
        r.voice = 0;
        add_row(r, 0, none);
        add_row(r, 0, none);
    endtask

    // receiver stall pattern
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else if (cycle_count % 97 < 40) m_ready <= 1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn && m_valid && m_ready) begin
            mix_result_t x, f;
            bit fx;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result L=%h R=%h", $time, m_left_out, m_right_out);
                fail_count++;
            end else begin
                x = expected_results.pop_front();
                fx = has_fixed.pop_front();
                f = fixed_results.pop_front();
                if (fx) x = f;
                if (m_left_out !== x.left_out || m_right_out !== x.right_out ||
                    m_voice_given !== x.voice_given || m_accepted !== x.accepted ||
                    m_active_voices !== x.active_voices) begin
                    $display("%0t: expected %h %h %0d %b %0d, actual %h %h %0d %b %0d",
                        $time, x.left_out, x.right_out, x.voice_given, x.accepted,
                        x.active_voices, m_left_out, m_right_out, m_voice_given,
                        m_accepted, m_active_voices);
                    fail_count++;
                end
            end
            seen_count++;
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        request_t r;
        mix_result_t none;
        int burst;
        int gap;
        none = '{default: 0};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        build_table();
        foreach (directed_rows[i]) send_req(directed_rows[i], directed_fixed[i], directed_exp[i]);
        // fill the playback region so no unwritten word is ever read
        for (int a = 0; a < REGION; a++) begin
            r = blank_req(REQ_WRITE);
            r.address = 16'(a);
            r.sample = 16'($urandom);
            send_req(r, 0, none);
        end
        for (int a = 16'hFFF0; a <= 16'hFFFF; a++) begin
            r = blank_req(REQ_WRITE);
            r.address = 16'(a);
            r.sample = 16'($urandom);
            send_req(r, 0, none);
        end
        r = blank_req(REQ_WRITE);
        for (int a = REGION; a < REGION + 40; a++) begin
            r.address = 16'(a);
            r.sample = 16'($urandom);
            send_req(r, 0, none);
        end
        for (int n = 0; n < RAND_ITEMS;) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && n < RAND_ITEMS; b++, n++)
                send_req(rand_req(), 0, none);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_valid <= 0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid <= 0;
        while (seen_count < sent_count) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
